// File: hdl/cbd_pkg.sv
// ----------------------------------------------------------------------------
// cbd_pkg
// Shared types, constants and helpers for the chunked body decoder.
// ----------------------------------------------------------------------------
package cbd_pkg;

  // Widths of the size accumulator and the consumed byte counter
  localparam int SIZE_BITS  = 32;
  localparam int COUNT_BITS = 32;
  localparam int CONS_BITS  = 32;
  localparam int HEX_RADIX  = 16;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // Parser phase, one-hot
  typedef enum logic [11:0] {
    PH_SIZE_FIRST  = 12'b0000_0000_0001,
    PH_SIZE_DIGITS = 12'b0000_0000_0010,
    PH_EXT         = 12'b0000_0000_0100,
    PH_DATA        = 12'b0000_0000_1000,
    PH_DATA_CR     = 12'b0000_0001_0000,
    PH_DATA_LF     = 12'b0000_0010_0000,
    PH_TRL_START   = 12'b0000_0100_0000,
    PH_TRL_CR      = 12'b0000_1000_0000,
    PH_TRL_LINE    = 12'b0001_0000_0000,
    PH_DONE        = 12'b0010_0000_0000,
    PH_ERROR       = 12'b0100_0000_0000,
    PH_ENDED       = 12'b1000_0000_0000
  } phase_t;

  // Status codes on the result channel
  typedef enum logic [1:0] {
    ST_RUNNING   = 2'd0,
    ST_COMPLETE  = 2'd1,
    ST_MALFORMED = 2'd2,
    ST_ENDED     = 2'd3
  } status_t;

  // Parser state carried from byte to byte
  typedef struct packed {
    phase_t                phase;
    logic [SIZE_BITS-1:0]  remaining;
    logic [COUNT_BITS-1:0] count;
  } parse_state_t;

  // One result item
  typedef struct packed {
    logic [7:0]           payload_byte;
    logic                 payload_valid;
    status_t              status;
    logic [CONS_BITS-1:0] consumed;
  } result_t;

  // Hex digit decode: bit 4 set means the byte is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'(HEX_RADIX);
    if (c >= "0" && c <= "9") begin
      v = 5'(c - 8'("0"));
    end else if (c >= "a" && c <= "f") begin
      v = 5'(c - 8'("a") + 8'd10);
    end else if (c >= "A" && c <= "F") begin
      v = 5'(c - 8'("A") + 8'd10);
    end
    return v;
  endfunction

endpackage

// File: hdl/cbd_parse.sv
// ----------------------------------------------------------------------------
// cbd_parse
// Next-state and result logic for one body byte of the chunked decoder.
// ----------------------------------------------------------------------------
module cbd_parse (
  input  cbd_pkg::parse_state_t cur,
  input  logic [7:0]            data_byte,
  input  logic                  start_of_body,
  input  logic                  end_of_body,
  output cbd_pkg::parse_state_t nxt,
  output cbd_pkg::result_t      res
);

  localparam logic [cbd_pkg::SIZE_BITS-1:0]  SIZE_MAX  = '1;
  localparam logic [cbd_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [cbd_pkg::CONS_BITS-1:0]  CONS_MAX  = '1;

  cbd_pkg::parse_state_t    base;
  logic [4:0]               hex_d;
  logic                     is_hex;
  logic                     running;
  logic                     pay_vld;
  logic [cbd_pkg::SIZE_BITS-1:0] acc_shift;
  logic [cbd_pkg::SIZE_BITS-1:0] rem_dec;
  logic [cbd_pkg::COUNT_BITS-1:0] cnt_out;

  // Start of body clears the parser before this byte is parsed
  always_comb begin
    if (start_of_body) begin
      base.phase     = cbd_pkg::PH_SIZE_FIRST;
      base.remaining = '0;
      base.count     = '0;
    end else begin
      base = cur;
    end
  end

  assign hex_d   = cbd_pkg::hex_value(data_byte);
  assign is_hex  = ~hex_d[4];
  assign running = (base.phase != cbd_pkg::PH_DONE) &&
                   (base.phase != cbd_pkg::PH_ERROR) &&
                   (base.phase != cbd_pkg::PH_ENDED);

  // Size accumulation, saturating at all ones
  always_comb begin
    if (base.remaining[cbd_pkg::SIZE_BITS-1 -: 4] != 4'd0) begin
      acc_shift = SIZE_MAX;
    end else begin
      acc_shift = {base.remaining[cbd_pkg::SIZE_BITS-5:0], hex_d[3:0]};
    end
  end

  assign rem_dec = (base.remaining != '0) ? base.remaining - 1'b1 : base.remaining;

  // Phase transitions
  always_comb begin
    nxt = base;
    pay_vld = 1'b0;
    if (running) begin
      if (base.count != COUNT_MAX) begin
        nxt.count = base.count + 1'b1;
      end
      case (base.phase)
        cbd_pkg::PH_SIZE_FIRST: begin
          if (is_hex) begin
            nxt.remaining = cbd_pkg::SIZE_BITS'(hex_d[3:0]);
            nxt.phase     = cbd_pkg::PH_SIZE_DIGITS;
          end else begin
            nxt.phase = cbd_pkg::PH_ERROR;
          end
        end
        cbd_pkg::PH_SIZE_DIGITS: begin
          if (is_hex) begin
            nxt.remaining = acc_shift;
          end else if (data_byte == cbd_pkg::CH_LF) begin
            nxt.phase = (base.remaining == '0) ? cbd_pkg::PH_TRL_START : cbd_pkg::PH_DATA;
          end else begin
            nxt.phase = cbd_pkg::PH_EXT;
          end
        end
        cbd_pkg::PH_EXT: begin
          if (data_byte == cbd_pkg::CH_LF) begin
            nxt.phase = (base.remaining == '0) ? cbd_pkg::PH_TRL_START : cbd_pkg::PH_DATA;
          end
        end
        cbd_pkg::PH_DATA: begin
          pay_vld       = 1'b1;
          nxt.remaining = rem_dec;
          if (rem_dec == '0) begin
            nxt.phase = cbd_pkg::PH_DATA_CR;
          end
        end
        cbd_pkg::PH_DATA_CR: begin
          nxt.phase = (data_byte == cbd_pkg::CH_CR) ? cbd_pkg::PH_DATA_LF : cbd_pkg::PH_ERROR;
        end
        cbd_pkg::PH_DATA_LF: begin
          nxt.phase = (data_byte == cbd_pkg::CH_LF) ? cbd_pkg::PH_SIZE_FIRST : cbd_pkg::PH_ERROR;
        end
        cbd_pkg::PH_TRL_START: begin
          if (data_byte == cbd_pkg::CH_LF) begin
            nxt.phase = cbd_pkg::PH_DONE;
          end else if (data_byte == cbd_pkg::CH_CR) begin
            nxt.phase = cbd_pkg::PH_TRL_CR;
          end else begin
            nxt.phase = cbd_pkg::PH_TRL_LINE;
          end
        end
        cbd_pkg::PH_TRL_CR: begin
          nxt.phase = (data_byte == cbd_pkg::CH_LF) ? cbd_pkg::PH_DONE : cbd_pkg::PH_TRL_LINE;
        end
        cbd_pkg::PH_TRL_LINE: begin
          if (data_byte == cbd_pkg::CH_LF) begin
            nxt.phase = cbd_pkg::PH_TRL_START;
          end
        end
        default: begin
          nxt.phase = base.phase;
        end
      endcase
      // Body ran out before the final empty line
      if (end_of_body && (nxt.phase != cbd_pkg::PH_DONE) &&
          (nxt.phase != cbd_pkg::PH_ERROR)) begin
        nxt.phase = cbd_pkg::PH_ENDED;
      end
    end
  end

  // Consumed count, clamped to the output width
  always_comb begin
    if (cbd_pkg::COUNT_BITS > cbd_pkg::CONS_BITS &&
        nxt.count > cbd_pkg::COUNT_BITS'(CONS_MAX)) begin
      cnt_out = cbd_pkg::COUNT_BITS'(CONS_MAX);
    end else begin
      cnt_out = nxt.count;
    end
  end

  // Status and result fields
  always_comb begin
    case (nxt.phase)
      cbd_pkg::PH_DONE:  res.status = cbd_pkg::ST_COMPLETE;
      cbd_pkg::PH_ERROR: res.status = cbd_pkg::ST_MALFORMED;
      cbd_pkg::PH_ENDED: res.status = cbd_pkg::ST_ENDED;
      default:           res.status = cbd_pkg::ST_RUNNING;
    endcase
    res.payload_valid = pay_vld;
    res.payload_byte  = pay_vld ? data_byte : 8'd0;
    res.consumed      = (nxt.phase == cbd_pkg::PH_DONE) ?
                        cbd_pkg::CONS_BITS'(cnt_out) : '0;
  end

endmodule

// File: hdl/http_chunked_body_decoder_core.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core
// Streams an HTTP chunked body byte by byte, passes out chunk data and
// reports completion with the byte count, malformed framing or early end.
// ----------------------------------------------------------------------------
//  channel | ports                                              | direction
//  --------+----------------------------------------------------+----------
//  input   | in_valid, in_stall, in_data_byte, in_start_of_body, | in
//          | in_end_of_body                                      |
//  result  | out_valid, out_stall, out_payload_byte,             | out
//          | out_payload_valid, out_status, out_consumed_bytes   |
//
// One byte per cycle while the result is not stalled: each accepted byte gives one result in the next cycle.
// The loop through the parser state register sets the rate; its path is a
// hex decode, a saturating shift or decrement, and the counter increment.
// Reset clears the phase, size and count; no clearing pass is needed.
// A stalled result holds the input side only while the result register is full.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_body,
  input  logic        in_end_of_body,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_payload_byte,
  output logic        out_payload_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_consumed_bytes
);

  cbd_pkg::parse_state_t state_r, state_nxt;
  cbd_pkg::result_t      res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  in_xfer;

  // Accept whenever the result register is free or being drained
  assign in_stall = out_valid_r & out_stall;
  assign in_xfer  = in_valid & ~in_stall;

  cbd_parse u_parse (
    .cur           (state_r),
    .data_byte     (in_data_byte),
    .start_of_body (in_start_of_body),
    .end_of_body   (in_end_of_body),
    .nxt           (state_nxt),
    .res           (res_nxt)
  );

  assign out_valid_nxt = in_xfer | (out_valid_r & out_stall);

  // Parser state and valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase     <= cbd_pkg::PH_SIZE_FIRST;
      state_r.remaining <= '0;
      state_r.count     <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_xfer) begin
        state_r <= state_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_payload_byte   = res_r.payload_byte;
  assign out_payload_valid  = res_r.payload_valid;
  assign out_status         = res_r.status;
  assign out_consumed_bytes = res_r.consumed;

`ifndef ASSERT_OFF
  // A data byte never completes or fails the body
  a_data_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_payload_valid) |->
      (out_status == cbd_pkg::ST_RUNNING || out_status == cbd_pkg::ST_ENDED))
    else $error("payload byte with complete or malformed status");

  // Count is reported only on completion
  a_count_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != cbd_pkg::ST_COMPLETE) |-> (out_consumed_bytes == '0))
    else $error("consumed count without completion");

  // Input is held back only by a full, stalled result register
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without pending result");

  // Every input transfer shows a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted byte produced no result");
`endif

endmodule
